// ----- design/rbh_pkg.sv -----
// shared types and constants for the ray box nearest hit picker
`timescale 1ns / 1ps
package rbh_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int CW        = 32;
    localparam int DIFF_W    = CW + 2;
    localparam int DIV_STEPS = 32;
    localparam int AXES      = 3;
    localparam int LANES     = 2 * AXES;

    localparam logic [0:0] OP_WRITE = 1'b0;
    localparam logic [0:0] OP_QUERY = 1'b1;

    typedef logic signed [CW-1:0] t_coord;

    localparam t_coord SAT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord SAT_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [AXES-1:0][CW-1:0] ctr;
        logic [AXES-1:0][CW-1:0] half;
    } t_box;

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [CW-1:0] low;
        logic [CW-1:0] quo;
        logic          sat;
        logic          neg;
    } t_lane;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [AXES-1:0]  par;
        logic             par_miss;
    } t_meta;

endpackage

// ----- design/rbh_req_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps
interface rbh_req_if;
    logic                       valid;
    logic                       ready;
    logic [0:0]                 opcode;
    logic [rbh_pkg::IDX_W-1:0]  box_index;
    logic signed [31:0]         vec_a_x;
    logic signed [31:0]         vec_a_y;
    logic signed [31:0]         vec_a_z;
    logic signed [31:0]         vec_b_x;
    logic signed [31:0]         vec_b_y;
    logic signed [31:0]         vec_b_z;

    modport source (output valid, opcode, box_index, vec_a_x, vec_a_y, vec_a_z,
                    vec_b_x, vec_b_y, vec_b_z, input ready);
    modport sink   (input valid, opcode, box_index, vec_a_x, vec_a_y, vec_a_z,
                    vec_b_x, vec_b_y, vec_b_z, output ready);
endinterface

interface rbh_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       hit_found;
    logic [rbh_pkg::IDX_W-1:0]  hit_index;

    modport source (output valid, hit_found, hit_index, input ready);
    modport sink   (input valid, hit_found, hit_index, output ready);
endinterface

// ----- design/rbh_box_mem.sv -----
// box table memory with one write port and one registered read port
`timescale 1ns / 1ps
module rbh_box_mem (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [rbh_pkg::IDX_W-1:0]  i_wr_addr,
    input  rbh_pkg::t_box              i_wr_data,
    input  logic                       i_rd_en,
    input  logic [rbh_pkg::IDX_W-1:0]  i_rd_addr,
    output rbh_pkg::t_box              o_rd_data
);

    rbh_pkg::t_box r_mem [rbh_pkg::MAX_BOXES];
    rbh_pkg::t_box r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/rbh_div_cell.sv -----
// one restoring division step for all six slab lanes
`timescale 1ns / 1ps
module rbh_div_cell (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic [rbh_pkg::AXES-1:0][rbh_pkg::CW-1:0] i_dmag,
    input  rbh_pkg::t_meta                            i_meta,
    input  rbh_pkg::t_lane [rbh_pkg::LANES-1:0]       i_lane,
    output rbh_pkg::t_meta                            o_meta,
    output rbh_pkg::t_lane [rbh_pkg::LANES-1:0]       o_lane
);

    rbh_pkg::t_meta                      r_meta;
    rbh_pkg::t_lane [rbh_pkg::LANES-1:0] r_lane;
    rbh_pkg::t_lane [rbh_pkg::LANES-1:0] n_lane;

    always_comb begin
        logic [rbh_pkg::CW:0] trial;
        logic [rbh_pkg::CW:0] dext;
        logic                 qbit;
        for (int l = 0; l < rbh_pkg::LANES; l++) begin
            trial = {i_lane[l].rem, i_lane[l].low[rbh_pkg::CW-1]};
            dext  = {1'b0, i_dmag[l/2]};
            qbit  = (trial >= dext);
            n_lane[l]     = i_lane[l];
            n_lane[l].rem = qbit ? rbh_pkg::CW'(trial - dext) : trial[rbh_pkg::CW-1:0];
            n_lane[l].low = {i_lane[l].low[rbh_pkg::CW-2:0], 1'b0};
            n_lane[l].quo = {i_lane[l].quo[rbh_pkg::CW-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta.vld <= 1'b0;
        end else begin
            r_meta.vld <= i_meta.vld;
        end
        r_meta.last     <= i_meta.last;
        r_meta.idx      <= i_meta.idx;
        r_meta.par      <= i_meta.par;
        r_meta.par_miss <= i_meta.par_miss;
        r_lane          <= n_lane;
    end

    assign o_meta = r_meta;
    assign o_lane = r_lane;

endmodule

// ----- design/rbh_hit_sel.sv -----
// slab distance finish, entry and exit reduction, nearest hit tracking
`timescale 1ns / 1ps
module rbh_hit_sel (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  rbh_pkg::t_meta                      i_meta,
    input  rbh_pkg::t_lane [rbh_pkg::LANES-1:0] i_lane,
    output logic                                o_done,
    output logic                                o_found,
    output logic [rbh_pkg::IDX_W-1:0]           o_idx
);

    rbh_pkg::t_meta                   r_s1_meta;
    rbh_pkg::t_coord [rbh_pkg::AXES-1:0] r_s1_tlo;
    rbh_pkg::t_coord [rbh_pkg::AXES-1:0] r_s1_thi;
    rbh_pkg::t_coord [rbh_pkg::AXES-1:0] n_s1_tlo;
    rbh_pkg::t_coord [rbh_pkg::AXES-1:0] n_s1_thi;

    rbh_pkg::t_meta  r_s2_meta;
    rbh_pkg::t_coord r_s2_tmin;
    rbh_pkg::t_coord r_s2_tmax;
    rbh_pkg::t_coord n_s2_tmin;
    rbh_pkg::t_coord n_s2_tmax;

    logic                      r_done;
    logic                      r_found;
    logic [rbh_pkg::IDX_W-1:0] r_best_idx;
    rbh_pkg::t_coord           r_best_t;
    logic                      w_hit;

    always_comb begin
        rbh_pkg::t_coord v [rbh_pkg::LANES];
        logic            big;
        for (int l = 0; l < rbh_pkg::LANES; l++) begin
            big = i_lane[l].sat | i_lane[l].quo[rbh_pkg::CW-1];
            if (i_lane[l].neg) begin
                v[l] = big ? rbh_pkg::SAT_MIN : rbh_pkg::t_coord'(-i_lane[l].quo);
            end else begin
                v[l] = big ? rbh_pkg::SAT_MAX : rbh_pkg::t_coord'(i_lane[l].quo);
            end
        end
        for (int a = 0; a < rbh_pkg::AXES; a++) begin
            if (v[2*a] > v[2*a+1]) begin
                n_s1_tlo[a] = v[2*a+1];
                n_s1_thi[a] = v[2*a];
            end else begin
                n_s1_tlo[a] = v[2*a];
                n_s1_thi[a] = v[2*a+1];
            end
        end
    end

    always_comb begin
        n_s2_tmin = rbh_pkg::SAT_MIN;
        n_s2_tmax = rbh_pkg::SAT_MAX;
        for (int a = 0; a < rbh_pkg::AXES; a++) begin
            if (!r_s1_meta.par[a]) begin
                if ($signed(r_s1_tlo[a]) > n_s2_tmin) begin
                    n_s2_tmin = r_s1_tlo[a];
                end
                if ($signed(r_s1_thi[a]) < n_s2_tmax) begin
                    n_s2_tmax = r_s1_thi[a];
                end
            end
        end
    end

    assign w_hit = r_s2_meta.vld && !r_s2_meta.par_miss && (r_s2_tmin <= r_s2_tmax)
                   && (r_s2_tmin >= 0) && (!r_found || (r_s2_tmin < r_best_t));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_meta.vld <= 1'b0;
            r_s2_meta.vld <= 1'b0;
            r_done        <= 1'b0;
            r_found       <= 1'b0;
            r_best_idx    <= '0;
        end else begin
            r_s1_meta.vld <= i_meta.vld;
            r_s2_meta.vld <= r_s1_meta.vld;
            r_done        <= r_s2_meta.vld && r_s2_meta.last;
            if (i_start) begin
                r_found    <= 1'b0;
                r_best_idx <= '0;
            end else if (w_hit) begin
                r_found    <= 1'b1;
                r_best_idx <= r_s2_meta.idx;
            end
        end
        r_s1_meta.last     <= i_meta.last;
        r_s1_meta.idx      <= i_meta.idx;
        r_s1_meta.par      <= i_meta.par;
        r_s1_meta.par_miss <= i_meta.par_miss;
        r_s1_tlo           <= n_s1_tlo;
        r_s1_thi           <= n_s1_thi;
        r_s2_meta.last     <= r_s1_meta.last;
        r_s2_meta.idx      <= r_s1_meta.idx;
        r_s2_meta.par      <= r_s1_meta.par;
        r_s2_meta.par_miss <= r_s1_meta.par_miss;
        r_s2_tmin          <= n_s2_tmin;
        r_s2_tmax          <= n_s2_tmax;
        if (w_hit && !i_start) begin
            r_best_t <= r_s2_tmin;
        end
    end

    assign o_done  = r_done;
    assign o_found = r_found;
    assign o_idx   = r_best_idx;

endmodule

// ----- design/ray_box_nearest_hit_pick.sv -----
// Nearest ray/box hit picker. A write transfer stores one box (center and half
// extents, Q16.16) in a 64-entry table; a query transfer sends the ray origin
// and direction through every examined box, one box per cycle, and returns
// one response transfer with the nearest hit. Each box flows through a chain
// of 32 divider cells, one quotient bit per cell for all six slab distances,
// then three compare stages. The request side is taken only when no query
// is running. box_count is written through i_cfg_wr_en/i_cfg_wr_data.
`timescale 1ns / 1ps
module ray_box_nearest_hit_pick (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [rbh_pkg::CNT_W-1:0]   i_cfg_wr_data,
    rbh_req_if.sink                     i_req,
    rbh_rsp_if.source                   o_rsp
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [rbh_pkg::CNT_W-1:0] r_box_count;
    logic [rbh_pkg::CNT_W-1:0] r_num;
    logic [rbh_pkg::CNT_W-1:0] w_num;
    logic [rbh_pkg::IDX_W-1:0] r_cnt;
    logic                      w_acc;
    logic                      w_query;
    logic                      w_issue;
    logic                      w_issue_last;
    logic                      w_sel_done;
    logic                      w_sel_found;
    logic [rbh_pkg::IDX_W-1:0] w_sel_idx;
    logic                      w_out_load;

    logic [rbh_pkg::AXES-1:0][rbh_pkg::CW-1:0] r_org;
    logic [rbh_pkg::AXES-1:0][rbh_pkg::CW-1:0] r_dmag;
    logic [rbh_pkg::AXES-1:0]                  r_par;
    logic [rbh_pkg::AXES-1:0]                  r_dneg;
    logic [rbh_pkg::AXES-1:0][rbh_pkg::CW-1:0] w_va;
    logic [rbh_pkg::AXES-1:0][rbh_pkg::CW-1:0] w_vb;

    rbh_pkg::t_box  w_wr_box;
    rbh_pkg::t_box  w_rd_box;
    rbh_pkg::t_meta r_rd_meta;

    rbh_pkg::t_meta r_f1_meta;
    rbh_pkg::t_meta n_f1_meta;
    logic signed [rbh_pkg::AXES-1:0][rbh_pkg::DIFF_W-1:0] r_f1_dlo;
    logic signed [rbh_pkg::AXES-1:0][rbh_pkg::DIFF_W-1:0] r_f1_dhi;
    logic signed [rbh_pkg::AXES-1:0][rbh_pkg::DIFF_W-1:0] n_f1_dlo;
    logic signed [rbh_pkg::AXES-1:0][rbh_pkg::DIFF_W-1:0] n_f1_dhi;

    rbh_pkg::t_meta                      r_f2_meta;
    rbh_pkg::t_lane [rbh_pkg::LANES-1:0] r_f2_lane;
    rbh_pkg::t_lane [rbh_pkg::LANES-1:0] n_f2_lane;

    rbh_pkg::t_meta                      w_meta [rbh_pkg::DIV_STEPS+1];
    rbh_pkg::t_lane [rbh_pkg::LANES-1:0] w_lane [rbh_pkg::DIV_STEPS+1];

    logic                      r_out_vld;
    logic                      r_out_found;
    logic [rbh_pkg::IDX_W-1:0] r_out_idx;

    assign w_va = {i_req.vec_a_z, i_req.vec_a_y, i_req.vec_a_x};
    assign w_vb = {i_req.vec_b_z, i_req.vec_b_y, i_req.vec_b_x};

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_query     = w_acc && (i_req.opcode == rbh_pkg::OP_QUERY);
    assign w_num       = (r_box_count > rbh_pkg::CNT_W'(rbh_pkg::MAX_BOXES))
                         ? rbh_pkg::CNT_W'(rbh_pkg::MAX_BOXES) : r_box_count;
    assign w_issue     = (r_state == ST_ISSUE);
    assign w_issue_last = w_issue && ({1'b0, r_cnt} == r_num - 1'b1);
    assign w_out_load  = (r_state == ST_DONE) && (!r_out_vld || o_rsp.ready);

    assign w_wr_box.ctr  = w_va;
    assign w_wr_box.half = w_vb;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_state = (w_num == '0) ? ST_DONE : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (w_issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_sel_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_box_count   <= '0;
            r_cnt         <= '0;
            r_rd_meta.vld <= 1'b0;
            r_f1_meta.vld <= 1'b0;
            r_f2_meta.vld <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_box_count <= i_cfg_wr_data;
            end
            if (w_query) begin
                r_cnt <= '0;
            end else if (w_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_rd_meta.vld <= w_issue;
            r_f1_meta.vld <= r_rd_meta.vld;
            r_f2_meta.vld <= r_f1_meta.vld;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (w_query) begin
            r_num <= w_num;
            for (int a = 0; a < rbh_pkg::AXES; a++) begin
                r_org[a]  <= w_va[a];
                r_par[a]  <= (w_vb[a] == '0);
                r_dmag[a] <= w_vb[a][rbh_pkg::CW-1] ? rbh_pkg::CW'(-w_vb[a]) : w_vb[a];
            end
        end
        r_rd_meta.last     <= w_issue_last;
        r_rd_meta.idx      <= r_cnt;
        r_rd_meta.par      <= r_par;
        r_rd_meta.par_miss <= 1'b0;
        r_f1_meta.last     <= n_f1_meta.last;
        r_f1_meta.idx      <= n_f1_meta.idx;
        r_f1_meta.par      <= n_f1_meta.par;
        r_f1_meta.par_miss <= n_f1_meta.par_miss;
        r_f1_dlo           <= n_f1_dlo;
        r_f1_dhi           <= n_f1_dhi;
        r_f2_meta.last     <= r_f1_meta.last;
        r_f2_meta.idx      <= r_f1_meta.idx;
        r_f2_meta.par      <= r_f1_meta.par;
        r_f2_meta.par_miss <= r_f1_meta.par_miss;
        r_f2_lane          <= n_f2_lane;
        if (w_out_load) begin
            r_out_found <= (r_num == '0) ? 1'b0 : w_sel_found;
            r_out_idx   <= (r_num == '0) ? '0 : w_sel_idx;
        end
    end

    rbh_box_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_acc && (i_req.opcode == rbh_pkg::OP_WRITE)),
        .i_wr_addr (i_req.box_index),
        .i_wr_data (w_wr_box),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_cnt),
        .o_rd_data (w_rd_box)
    );

    // slab bounds relative to the origin
    always_comb begin
        logic signed [rbh_pkg::CW:0]       lo;
        logic signed [rbh_pkg::CW:0]       hi;
        logic signed [rbh_pkg::DIFF_W-1:0] o;
        n_f1_meta          = r_rd_meta;
        n_f1_meta.par_miss = 1'b0;
        for (int a = 0; a < rbh_pkg::AXES; a++) begin
            lo = $signed({w_rd_box.ctr[a][rbh_pkg::CW-1], w_rd_box.ctr[a]})
               - $signed({w_rd_box.half[a][rbh_pkg::CW-1], w_rd_box.half[a]});
            hi = $signed({w_rd_box.ctr[a][rbh_pkg::CW-1], w_rd_box.ctr[a]})
               + $signed({w_rd_box.half[a][rbh_pkg::CW-1], w_rd_box.half[a]});
            o  = $signed({{2{r_org[a][rbh_pkg::CW-1]}}, r_org[a]});
            n_f1_dlo[a] = $signed({lo[rbh_pkg::CW], lo}) - o;
            n_f1_dhi[a] = $signed({hi[rbh_pkg::CW], hi}) - o;
            if (r_par[a] && (($signed({lo[rbh_pkg::CW], lo}) > o) ||
                             ($signed({hi[rbh_pkg::CW], hi}) < o))) begin
                n_f1_meta.par_miss = 1'b1;
            end
        end
    end

    // divider lane setup: magnitude, sign, early saturation
    always_comb begin
        logic [rbh_pkg::DIFF_W-1:0] d;
        logic [rbh_pkg::DIFF_W-1:0] mag;
        for (int l = 0; l < rbh_pkg::LANES; l++) begin
            d   = l[0] ? r_f1_dhi[l/2] : r_f1_dlo[l/2];
            mag = d[rbh_pkg::DIFF_W-1] ? rbh_pkg::DIFF_W'(-d) : d;
            n_f2_lane[l].neg = d[rbh_pkg::DIFF_W-1] ^ r_dneg[l/2];
            n_f2_lane[l].sat = (rbh_pkg::CW'(mag[rbh_pkg::DIFF_W-1:16]) >= r_dmag[l/2]);
            n_f2_lane[l].rem = rbh_pkg::CW'(mag[rbh_pkg::DIFF_W-1:16]);
            n_f2_lane[l].low = {mag[15:0], 16'h0000};
            n_f2_lane[l].quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            for (int a = 0; a < rbh_pkg::AXES; a++) begin
                r_dneg[a] <= w_vb[a][rbh_pkg::CW-1];
            end
        end
    end

    assign w_meta[0] = r_f2_meta;
    assign w_lane[0] = r_f2_lane;

    for (genvar g = 0; g < rbh_pkg::DIV_STEPS; g++) begin : g_cell
        rbh_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_dmag  (r_dmag),
            .i_meta  (w_meta[g]),
            .i_lane  (w_lane[g]),
            .o_meta  (w_meta[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    rbh_hit_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_query),
        .i_meta  (w_meta[rbh_pkg::DIV_STEPS]),
        .i_lane  (w_lane[rbh_pkg::DIV_STEPS]),
        .o_done  (w_sel_done),
        .o_found (w_sel_found),
        .o_idx   (w_sel_idx)
    );

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.hit_found = r_out_found;
    assign o_rsp.hit_index = r_out_idx;

endmodule
